// ===== hw/rtl/c8alu_pkg.sv =====
// shared types and codes for the eight-bit flag alu
package c8alu_pkg;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 5;
    localparam int BIDX_W  = 3;
    localparam int FLAGS_W = 4;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLCA = 5'd10,
        OP_RRCA = 5'd11,
        OP_RLA  = 5'd12,
        OP_RRA  = 5'd13,
        OP_RLC  = 5'd14,
        OP_RRC  = 5'd15,
        OP_RL   = 5'd16,
        OP_RR   = 5'd17,
        OP_SLA  = 5'd18,
        OP_SRA  = 5'd19,
        OP_SRL  = 5'd20,
        OP_SWAP = 5'd21,
        OP_BIT  = 5'd22,
        OP_RES  = 5'd23,
        OP_SET  = 5'd24,
        OP_CPL  = 5'd25,
        OP_SCF  = 5'd26,
        OP_CCF  = 5'd27
    } t_alu_kind;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  accumulator;
        logic [DATA_W-1:0]  operand;
        logic [BIDX_W-1:0]  bit_index;
        logic [FLAGS_W-1:0] flags_in;
    } t_op_item;

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [FLAGS_W-1:0] flags_out;
        logic               write_back;
    } t_res_item;

endpackage

// ===== hw/rtl/c8alu_if.sv =====
// valid/ready channels for alu operations and alu results
interface c8alu_op_if import c8alu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  accumulator;
    logic [DATA_W-1:0]  operand;
    logic [BIDX_W-1:0]  bit_index;
    logic [FLAGS_W-1:0] flags_in;

    modport source (
        output valid, kind, accumulator, operand, bit_index, flags_in,
        input  ready
    );
    modport sink (
        input  valid, kind, accumulator, operand, bit_index, flags_in,
        output ready
    );
endinterface

interface c8alu_res_if import c8alu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  result;
    logic [FLAGS_W-1:0] flags_out;
    logic               write_back;

    modport source (
        output valid, result, flags_out, write_back,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out, write_back,
        output ready
    );
endinterface

// ===== hw/rtl/c8alu_core.sv =====
// combinational datapath: result byte, flags and write-back for one item
module c8alu_core import c8alu_pkg::*; (
    input  t_op_item  i_item,
    output t_res_item o_res
);

    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  v;
    logic               cin;
    logic               zin;
    logic               cy;
    logic [DATA_W:0]    sum;
    logic [4:0]         sum_lo;
    logic [DATA_W:0]    diff;
    logic [4:0]         diff_lo;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  r;
    logic               z;
    logic               n;
    logic               h;
    logic               c;
    logic               keep_flags;

    assign a    = i_item.accumulator;
    assign v    = i_item.operand;
    assign cin  = i_item.flags_in[FLAG_C];
    assign zin  = i_item.flags_in[FLAG_Z];
    assign mask = DATA_W'(8'h01 << i_item.bit_index);

    // carry-in only for the with-carry forms
    assign cy = cin & ((i_item.kind == OP_ADC) || (i_item.kind == OP_SBC));

    assign sum     = {1'b0, a} + {1'b0, v} + {{DATA_W{1'b0}}, cy};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cy};
    assign diff    = {1'b0, a} - {1'b0, v} - {{DATA_W{1'b0}}, cy};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, cy};

    always_comb begin
        r                = '0;
        z                = zin;
        n                = 1'b0;
        h                = 1'b0;
        c                = cin;
        keep_flags       = 1'b0;
        o_res.write_back = 1'b1;
        unique case (i_item.kind)
            OP_ADD, OP_ADC: begin
                r = sum[DATA_W-1:0];
                z = (r == '0);
                h = sum_lo[4];
                c = sum[DATA_W];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r = diff[DATA_W-1:0];
                z = (r == '0);
                n = 1'b1;
                h = diff_lo[4];
                c = diff[DATA_W];
                o_res.write_back = (i_item.kind != OP_CP);
            end
            OP_AND: begin
                r = a & v;
                z = (r == '0);
                h = 1'b1;
                c = 1'b0;
            end
            OP_XOR: begin
                r = a ^ v;
                z = (r == '0);
                c = 1'b0;
            end
            OP_OR: begin
                r = a | v;
                z = (r == '0);
                c = 1'b0;
            end
            OP_INC: begin
                r = v + 8'd1;
                z = (r == '0);
                h = (v[3:0] == 4'hF);
            end
            OP_DEC: begin
                r = v - 8'd1;
                z = (r == '0);
                n = 1'b1;
                h = (v[3:0] == 4'h0);
            end
            OP_RLCA: begin
                r = {a[6:0], a[7]};
                z = 1'b0;
                c = a[7];
            end
            OP_RRCA: begin
                r = {a[0], a[7:1]};
                z = 1'b0;
                c = a[0];
            end
            OP_RLA: begin
                r = {a[6:0], cin};
                z = 1'b0;
                c = a[7];
            end
            OP_RRA: begin
                r = {cin, a[7:1]};
                z = 1'b0;
                c = a[0];
            end
            OP_RLC: begin
                r = {v[6:0], v[7]};
                z = (r == '0);
                c = v[7];
            end
            OP_RRC: begin
                r = {v[0], v[7:1]};
                z = (r == '0);
                c = v[0];
            end
            OP_RL: begin
                r = {v[6:0], cin};
                z = (r == '0);
                c = v[7];
            end
            OP_RR: begin
                r = {cin, v[7:1]};
                z = (r == '0);
                c = v[0];
            end
            OP_SLA: begin
                r = {v[6:0], 1'b0};
                z = (r == '0);
                c = v[7];
            end
            OP_SRA: begin
                r = {v[7], v[7:1]};
                z = (r == '0);
                c = v[0];
            end
            OP_SRL: begin
                r = {1'b0, v[7:1]};
                z = (r == '0);
                c = v[0];
            end
            OP_SWAP: begin
                r = {v[3:0], v[7:4]};
                z = (r == '0);
                c = 1'b0;
            end
            OP_BIT: begin
                r = v;
                z = ((v & mask) == '0);
                h = 1'b1;
                o_res.write_back = 1'b0;
            end
            OP_RES: begin
                r          = v & ~mask;
                keep_flags = 1'b1;
            end
            OP_SET: begin
                r          = v | mask;
                keep_flags = 1'b1;
            end
            OP_CPL: begin
                r = ~a;
                n = 1'b1;
                h = 1'b1;
            end
            OP_SCF: begin
                r = a;
                c = 1'b1;
                o_res.write_back = 1'b0;
            end
            OP_CCF: begin
                r = a;
                c = ~cin;
                o_res.write_back = 1'b0;
            end
            default: begin
                // unassigned codes: zero result, flags pass through
                r                = '0;
                keep_flags       = 1'b1;
                o_res.write_back = 1'b0;
            end
        endcase
        o_res.result    = r;
        o_res.flags_out = keep_flags ? i_item.flags_in : {z, n, h, c};
    end

endmodule

// ===== hw/rtl/cpu_8bit_alu_with_flags.sv =====
// top level of the eight-bit flag alu: input register, datapath, result register
//
// Eight-bit accumulator alu with Z/N/H/C flags. Each item on i_op carries an
// operation kind, the accumulator, an operand byte, a bit index and the
// current flags; each item on o_res returns the result byte, the new flags
// and a write-back strobe (low for compare, bit test, scf, ccf and the
// unassigned kinds 28 to 31). Every operation item produces exactly one
// result item, in order. The block takes one item per clock cycle unless
// o_res stalls, and holds no architectural state. An item is captured in
// the input register, passes the single-level datapath and lands in the
// result register once that register is free or being drained; only then
// is its result offered on o_res. The two registers form a pipeline with
// stall propagation: i_op.ready stays high while the result register is
// free or being drained, so the sink seeing o_res.ready low is the only
// thing that stops the flow.
module cpu_8bit_alu_with_flags import c8alu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c8alu_op_if.sink     i_op,
    c8alu_res_if.source  o_res
);

    // input stage
    logic      r_s1_valid;
    logic      n_s1_valid;
    t_op_item  r_s1;
    t_op_item  in_item;

    // result stage
    logic      r_out_valid;
    logic      n_out_valid;
    t_res_item r_out;
    t_res_item core_res;

    logic      in_fire;
    logic      s2_en;

    assign in_item = '{
        kind:        i_op.kind,
        accumulator: i_op.accumulator,
        operand:     i_op.operand,
        bit_index:   i_op.bit_index,
        flags_in:    i_op.flags_in
    };

    // result register can load when empty or drained this cycle
    assign s2_en      = !r_out_valid || o_res.ready;
    assign i_op.ready = !r_s1_valid || s2_en;
    assign in_fire    = i_op.valid && i_op.ready;

    assign n_s1_valid  = in_fire || (r_s1_valid && !s2_en);
    assign n_out_valid = s2_en ? r_s1_valid : r_out_valid;

    c8alu_core u_core (
        .i_item (r_s1),
        .o_res  (core_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= in_item;
        end
        if (s2_en && r_s1_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.result     = r_out.result;
    assign o_res.flags_out  = r_out.flags_out;
    assign o_res.write_back = r_out.write_back;

`ifndef SYNTHESIS
    // an accepted item always occupies the input stage next cycle
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted item not captured in input stage");

    // a staged item moves to the result register when it is free
    a_s2_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_en |=> r_out_valid)
        else $error("staged item not moved to result register");

    // a stalled input stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_en |=> r_s1_valid && $stable(r_s1))
        else $error("input stage lost its item under stall");

    // compare never writes back
    a_cp_nowb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_en && (r_s1.kind == OP_CP) |=> !o_res.write_back)
        else $error("compare result flagged for write-back");
`endif

endmodule
